[rtl/core/dcpf_pkg.sv]
`default_nettype none

package dcpf_pkg;

    // Default sizes and fixed field widths.
    localparam int MAX_ENTRIES_DEF = 64;
    localparam int COORD_BITS_DEF  = 20;
    localparam int IDX_W           = 16;
    localparam int TOL_W           = 16;
    localparam int OUT_W           = 6;
    localparam logic [TOL_W-1:0] TOL_RESET = 16'd256;

    // Number of coordinates held per entry: x, y and z for position A, then for B.
    localparam int N_COORD = 6;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       ld_new;
        logic       rd_en;
        logic       check;
        logic       sq_en;
        logic [1:0] sq_sel;
        logic       root_en;
        logic       cmp_en;
        logic       flush;
    } t_cmd;

endpackage

`default_nettype wire

[rtl/core/dcpf_ram.sv]
`default_nettype none

module dcpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/dcpf_datapath.sv]
`default_nettype none

module dcpf_datapath
    import dcpf_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [TOL_W-1:0]               i_cfg_data,
    input  wire t_cmd                           i_cmd,
    input  wire logic [$clog2(MAX_ENTRIES)-1:0] i_wr_addr,
    input  wire logic [$clog2(MAX_ENTRIES)-1:0] i_rd_addr,
    input  wire logic [IDX_W-1:0]               i_index_in_x,
    input  wire logic [IDX_W-1:0]               i_index_in_y,
    input  wire logic signed [COORD_BITS-1:0]   i_pos_x_a,
    input  wire logic signed [COORD_BITS-1:0]   i_pos_y_a,
    input  wire logic signed [COORD_BITS-1:0]   i_pos_z_a,
    input  wire logic signed [COORD_BITS-1:0]   i_pos_x_b,
    input  wire logic signed [COORD_BITS-1:0]   i_pos_y_b,
    input  wire logic signed [COORD_BITS-1:0]   i_pos_z_b,
    output logic                                o_idx_eq,
    output logic                                o_strobe,
    output logic [OUT_W-1:0]                    o_earlier_entry,
    output logic [OUT_W-1:0]                    o_later_entry,
    output logic                                o_last_pair
);

    localparam int AW  = $clog2(MAX_ENTRIES);
    localparam int CB  = COORD_BITS;
    localparam int SW  = 2 * CB + 2;
    localparam int RW  = CB + 1;
    localparam int MW  = 2 * IDX_W + N_COORD * CB;
    localparam int DCW = (RW > TOL_W) ? RW : TOL_W;

    logic [TOL_W-1:0]         r_tol;
    logic [IDX_W-1:0]         r_new_ix, r_new_iy;
    logic signed [CB-1:0]     r_new [N_COORD];
    logic [AW-1:0]            r_pos;
    logic [MW-1:0]            w_wdata, w_rdata;
    logic [CB-1:0]            r_mag_a [3];
    logic [CB-1:0]            r_mag_b [3];
    logic [SW-1:0]            r_rad_a, r_rad_b;
    logic [RW:0]              r_rem_a, r_rem_b;
    logic [RW-1:0]            r_root_a, r_root_b;
    logic                     r_pend;
    logic [AW-1:0]            r_pend_k;
    logic                     r_strobe;
    logic [OUT_W-1:0]         r_earlier, r_later;
    logic                     r_last;
    logic [CB-1:0]            w_mag [N_COORD];
    logic [CB-1:0]            w_ma, w_mb;
    logic [RW+2:0]            w_rem2_a, w_rem2_b, w_trial_a, w_trial_b;
    logic [RW-1:0]            w_rdiff;
    logic                     w_hit;

    // Entry layout: indices in the low bits, then six coordinates.
    assign w_wdata = {i_pos_z_b, i_pos_y_b, i_pos_x_b, i_pos_z_a, i_pos_y_a, i_pos_x_a,
                      i_index_in_y, i_index_in_x};

    dcpf_ram #(
        .WIDTH (MW),
        .DEPTH (MAX_ENTRIES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ld_new),
        .i_waddr (i_wr_addr),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (i_rd_addr),
        .o_rdata (w_rdata)
    );

    // Tolerance register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_data;
        end
    end

    // Hold the arriving entry for the whole comparison pass.
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_new) begin
            r_new_ix <= i_index_in_x;
            r_new_iy <= i_index_in_y;
            r_new[0] <= i_pos_x_a;
            r_new[1] <= i_pos_y_a;
            r_new[2] <= i_pos_z_a;
            r_new[3] <= i_pos_x_b;
            r_new[4] <= i_pos_y_b;
            r_new[5] <= i_pos_z_b;
            r_pos    <= i_wr_addr;
        end
    end

    // A stored entry is skipped when either index matches.
    assign o_idx_eq = (w_rdata[IDX_W-1:0] == r_new_ix) ||
                      (w_rdata[2*IDX_W-1:IDX_W] == r_new_iy);

    // Absolute coordinate differences against the stored entry.
    always_comb begin
        for (int i = 0; i < N_COORD; i++) begin
            logic signed [CB:0] d;
            d = {r_new[i][CB-1], r_new[i]} -
                {w_rdata[2*IDX_W+i*CB+CB-1], w_rdata[2*IDX_W+i*CB +: CB]};
            w_mag[i] = d[CB] ? CB'(-d) : d[CB-1:0];
        end
    end

    assign w_ma = r_mag_a[i_cmd.sq_sel];
    assign w_mb = r_mag_b[i_cmd.sq_sel];

    // One square root bit per step for each structure.
    assign w_rem2_a  = {r_rem_a, r_rad_a[SW-1:SW-2]};
    assign w_rem2_b  = {r_rem_b, r_rad_b[SW-1:SW-2]};
    assign w_trial_a = {1'b0, r_root_a, 2'b01};
    assign w_trial_b = {1'b0, r_root_b, 2'b01};

    // Squares, accumulation and square root steps.
    always_ff @(posedge i_clk) begin
        if (i_cmd.check) begin
            for (int i = 0; i < 3; i++) begin
                r_mag_a[i] <= w_mag[i];
                r_mag_b[i] <= w_mag[i+3];
            end
            r_rad_a  <= '0;
            r_rad_b  <= '0;
            r_rem_a  <= '0;
            r_rem_b  <= '0;
            r_root_a <= '0;
            r_root_b <= '0;
        end else if (i_cmd.sq_en) begin
            r_rad_a <= r_rad_a + SW'(w_ma * w_ma);
            r_rad_b <= r_rad_b + SW'(w_mb * w_mb);
        end else if (i_cmd.root_en) begin
            r_rad_a <= {r_rad_a[SW-3:0], 2'b00};
            r_rad_b <= {r_rad_b[SW-3:0], 2'b00};
            if (w_rem2_a >= w_trial_a) begin
                r_rem_a  <= (RW + 1)'(w_rem2_a - w_trial_a);
                r_root_a <= {r_root_a[RW-2:0], 1'b1};
            end else begin
                r_rem_a  <= w_rem2_a[RW:0];
                r_root_a <= {r_root_a[RW-2:0], 1'b0};
            end
            if (w_rem2_b >= w_trial_b) begin
                r_rem_b  <= (RW + 1)'(w_rem2_b - w_trial_b);
                r_root_b <= {r_root_b[RW-2:0], 1'b1};
            end else begin
                r_rem_b  <= w_rem2_b[RW:0];
                r_root_b <= {r_root_b[RW-2:0], 1'b0};
            end
        end
    end

    assign w_rdiff = (r_root_a > r_root_b) ? (r_root_a - r_root_b) : (r_root_b - r_root_a);
    assign w_hit   = DCW'(w_rdiff) <= DCW'(r_tol);

    // One pair is held back so that the final one can be flagged.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            if (i_cmd.cmp_en && w_hit) begin
                r_pend   <= 1'b1;
                r_pend_k <= i_rd_addr;
                if (r_pend) begin
                    r_strobe  <= 1'b1;
                    r_earlier <= OUT_W'(r_pend_k);
                    r_later   <= OUT_W'(r_pos);
                    r_last    <= 1'b0;
                end
            end else if (i_cmd.flush) begin
                r_pend <= 1'b0;
                if (r_pend) begin
                    r_strobe  <= 1'b1;
                    r_earlier <= OUT_W'(r_pend_k);
                    r_later   <= OUT_W'(r_pos);
                    r_last    <= 1'b1;
                end
            end
        end
    end

    assign o_strobe        = r_strobe;
    assign o_earlier_entry = r_earlier;
    assign o_later_entry   = r_later;
    assign o_last_pair     = r_last;

    // A result only follows a compare or the end of a pass.
    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> $past(i_cmd.cmp_en || i_cmd.flush))
        else $error("result without compare or flush");

    // The final pair of an arrival comes from the flush.
    a_last_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_last) |-> $past(i_cmd.flush))
        else $error("last pair outside flush");

endmodule

`default_nettype wire

[rtl/core/dcpf_ctrl.sv]
`default_nettype none

module dcpf_ctrl
    import dcpf_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic                           i_first_of_set,
    input  wire logic                           i_idx_eq,
    output logic                                o_busy,
    output t_cmd                                o_cmd,
    output logic [$clog2(MAX_ENTRIES)-1:0]      o_wr_addr,
    output logic [$clog2(MAX_ENTRIES)-1:0]      o_rd_addr
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int SW = $clog2(COORD_BITS + 2);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_READ  = 7'b0000010,
        S_CHECK = 7'b0000100,
        S_SQ    = 7'b0001000,
        S_ROOT  = 7'b0010000,
        S_CMP   = 7'b0100000,
        S_FLUSH = 7'b1000000
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_k, n_k;
    logic [AW-1:0] r_pos, n_pos;
    logic [SW-1:0] r_step, n_step;
    logic [CW-1:0] w_eff;
    logic          w_accept;
    logic          w_end;

    assign w_accept = i_start && (r_state == S_IDLE);
    assign w_eff    = i_first_of_set ? '0 : r_count;
    assign w_end    = (r_k == AW'(r_pos - 1'b1));

    // Sequencing of one arrival over all stored entries.
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_k     = r_k;
        n_pos   = r_pos;
        n_step  = r_step;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_first_of_set) begin
                        n_count = '0;
                    end
                    if (w_eff < CW'(MAX_ENTRIES)) begin
                        o_cmd.ld_new = 1'b1;
                        n_pos   = w_eff[AW-1:0];
                        n_count = w_eff + 1'b1;
                        n_k     = '0;
                        if (w_eff != '0) begin
                            n_state = S_READ;
                        end
                    end
                end
            end
            S_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_step      = '0;
                if (!i_idx_eq) begin
                    n_state = S_SQ;
                end else if (w_end) begin
                    n_state = S_FLUSH;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_READ;
                end
            end
            S_SQ: begin
                o_cmd.sq_en  = 1'b1;
                o_cmd.sq_sel = r_step[1:0];
                if (r_step == SW'(2)) begin
                    n_step  = '0;
                    n_state = S_ROOT;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_ROOT: begin
                o_cmd.root_en = 1'b1;
                if (r_step == SW'(COORD_BITS)) begin
                    n_state = S_CMP;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_CMP: begin
                o_cmd.cmp_en = 1'b1;
                if (w_end) begin
                    n_state = S_FLUSH;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_READ;
                end
            end
            S_FLUSH: begin
                o_cmd.flush = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_k     <= '0;
            r_pos   <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_k     <= n_k;
            r_pos   <= n_pos;
            r_step  <= n_step;
        end
    end

    assign o_busy    = (r_state != S_IDLE);
    assign o_wr_addr = n_pos;
    assign o_rd_addr = r_k;

    // The store never holds more than its capacity.
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ENTRIES))
        else $error("entry count above capacity");

    // Only entries stored before the new one are visited.
    a_k_below_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_k < r_pos))
        else $error("visited entry not below new position");

    // An accepted arrival that is stored leaves the count one above its position.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && o_cmd.ld_new) |=> (r_count == CW'(r_pos) + 1'b1))
        else $error("count does not follow stored position");

endmodule

`default_nettype wire

[rtl/core/distance_consistent_pair_finder_core.sv]
`default_nettype none

// Channel     Handshake              Ports
// ---------   --------------------   ------------------------------------------
// arrival     i_start & !o_busy      i_first_of_set, i_index_in_*, i_pos_*_a/b
// pair        o_strobe, one cycle    o_earlier_entry, o_later_entry, o_last_pair
// tolerance   i_cfg_we               i_cfg_data
//
// An arrival is accepted and stored; each stored entry is then read, checked,
// and skipped on an index match or else squared, rooted and compared. A flush
// closes the pass if any entry was visited. The two square roots yield one bit
// per cycle each. Reset is synchronous and active low; it empties the store and
// sets the tolerance to 256. The receiver cannot stall: each pair is shown once.
module distance_consistent_pair_finder_core
    import dcpf_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [TOL_W-1:0]             i_cfg_data,
    input  wire logic                         i_start,
    output logic                              o_busy,
    input  wire logic                         i_first_of_set,
    input  wire logic [IDX_W-1:0]             i_index_in_x,
    input  wire logic [IDX_W-1:0]             i_index_in_y,
    input  wire logic signed [COORD_BITS-1:0] i_pos_x_a,
    input  wire logic signed [COORD_BITS-1:0] i_pos_y_a,
    input  wire logic signed [COORD_BITS-1:0] i_pos_z_a,
    input  wire logic signed [COORD_BITS-1:0] i_pos_x_b,
    input  wire logic signed [COORD_BITS-1:0] i_pos_y_b,
    input  wire logic signed [COORD_BITS-1:0] i_pos_z_b,
    output logic                              o_strobe,
    output logic [OUT_W-1:0]                  o_earlier_entry,
    output logic [OUT_W-1:0]                  o_later_entry,
    output logic                              o_last_pair
);

    localparam int AW = $clog2(MAX_ENTRIES);

    t_cmd          w_cmd;
    logic          w_idx_eq;
    logic [AW-1:0] w_wr_addr, w_rd_addr;

    // Sequencer.
    dcpf_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .COORD_BITS  (COORD_BITS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .i_first_of_set (i_first_of_set),
        .i_idx_eq       (w_idx_eq),
        .o_busy         (o_busy),
        .o_cmd          (w_cmd),
        .o_wr_addr      (w_wr_addr),
        .o_rd_addr      (w_rd_addr)
    );

    // Store, distance arithmetic and result register.
    dcpf_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .COORD_BITS  (COORD_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (w_cmd),
        .i_wr_addr       (w_wr_addr),
        .i_rd_addr       (w_rd_addr),
        .i_index_in_x    (i_index_in_x),
        .i_index_in_y    (i_index_in_y),
        .i_pos_x_a       (i_pos_x_a),
        .i_pos_y_a       (i_pos_y_a),
        .i_pos_z_a       (i_pos_z_a),
        .i_pos_x_b       (i_pos_x_b),
        .i_pos_y_b       (i_pos_y_b),
        .i_pos_z_b       (i_pos_z_b),
        .o_idx_eq        (w_idx_eq),
        .o_strobe        (o_strobe),
        .o_earlier_entry (o_earlier_entry),
        .o_later_entry   (o_later_entry),
        .o_last_pair     (o_last_pair)
    );

endmodule

`default_nettype wire
